FILE: hdl/dhd_pkg.sv
// Shared types, codes and constants of the double-hash dictionary.
package dhd_pkg;

	localparam int DEF_TABLE_SLOTS = 4093;
	localparam int DEF_MAX_LEN = 12;

	localparam int NUM_SYM = 12;
	localparam int LEN_W = 4;
	localparam int SYM_W = 2 * NUM_SYM;
	localparam int ENTRY_W = LEN_W + SYM_W;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_FIND   = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ABSENT  = 2'd0,
		ST_PRESENT = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// One normalized request as it travels from the front to the back.
	typedef struct packed {
		cmd_t                    cmd;
		logic                    zero_len;
		logic [LEN_W-1:0]        len;
		logic [NUM_SYM-1:0][1:0] syms;
	} job_t;

	localparam int JOB_W = $bits(job_t);

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_READ,
		B_CHECK
	} back_state_t;

endpackage

FILE: hdl/dhd_front.sv
// Front end: takes a request, normalizes it and computes both hash residues.
module dhd_front import dhd_pkg::*; #(
	parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
	parameter int MAX_LEN = DEF_MAX_LEN,
	parameter int SLOT_W = $clog2(TABLE_SLOTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              enable,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [LEN_W-1:0]  length,
	input  logic [SYM_W-1:0]  symbols,
	output logic              push_valid,
	input  logic              push_ready,
	output job_t              push_job,
	output logic [SLOT_W-1:0] push_pos,
	output logic [SLOT_W-1:0] push_step
);

	localparam int T_W = SLOT_W + 3;
	localparam logic [T_W-1:0] MOD_A = T_W'(TABLE_SLOTS);
	localparam logic [T_W-1:0] MOD_B = T_W'(TABLE_SLOTS - 1);

	front_state_t            state_q, state_nx;
	job_t                    job_q;
	logic [LEN_W-1:0]        idx_q;
	logic [SLOT_W-1:0]       ra_q, rb_q;
	logic [LEN_W-1:0]        len_sat;
	logic [NUM_SYM-1:0][1:0] sym_m;
	logic [2:0]              code;
	logic                    accept;

	// Reduces t < 5*m into [0, m) by taking off the largest fitting multiple.
	function automatic logic [SLOT_W-1:0] reduce(input logic [T_W-1:0] t,
			input logic [T_W-1:0] m);
		logic [T_W-1:0] r;
		r = t;
		if (t >= (m << 2)) begin
			r = t - (m << 2);
		end else if (t >= (m << 1) + m) begin
			r = t - ((m << 1) + m);
		end else if (t >= (m << 1)) begin
			r = t - (m << 1);
		end else if (t >= m) begin
			r = t - m;
		end
		return r[SLOT_W-1:0];
	endfunction

	always_comb begin
		len_sat = (length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : length;
		for (int i = 0; i < NUM_SYM; i++) begin
			sym_m[i] = (LEN_W'(i) < len_sat) ? symbols[2*i +: 2] : 2'b00;
		end
	end

	assign accept = in_valid && in_ready;
	assign code = {1'b0, job_q.syms[idx_q]} + 3'd1;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_nx = (len_sat == '0) ? F_PUSH : F_HASH;
				end
			end
			F_HASH: begin
				if (idx_q == '0) begin
					state_nx = F_PUSH;
				end
			end
			F_PUSH: begin
				if (push_ready) begin
					state_nx = F_IDLE;
				end
			end
			default: state_nx = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == F_IDLE) && enable;
		push_valid = (state_q == F_PUSH);
		push_job = job_q;
		push_pos = ra_q;
		push_step = rb_q + SLOT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Horner evaluation from the highest symbol down, reduced every step.
	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.cmd <= cmd_t'(cmd);
			job_q.zero_len <= (len_sat == '0);
			job_q.len <= len_sat;
			job_q.syms <= sym_m;
			idx_q <= len_sat - LEN_W'(1);
			ra_q <= '0;
			rb_q <= '0;
		end else if (state_q == F_HASH) begin
			ra_q <= reduce((T_W'(ra_q) << 2) + T_W'(ra_q) + T_W'(code), MOD_A);
			rb_q <= reduce((T_W'(rb_q) << 2) + T_W'(rb_q) + T_W'(code), MOD_B);
			idx_q <= idx_q - LEN_W'(1);
		end
	end

endmodule

FILE: hdl/dhd_queue.sv
// Two-entry queue that decouples the hashing front from the probing back.
module dhd_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] buf_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;
	logic         push, pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data = buf_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_data;
		end
	end

endmodule

FILE: hdl/dhd_back.sv
// Back end: owns the slot table, walks the probe sequence and holds the result.
module dhd_back import dhd_pkg::*; #(
	parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
	parameter int SLOT_W = $clog2(TABLE_SLOTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	output logic              clearing,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  job_t              pop_job,
	input  logic [SLOT_W-1:0] pop_pos,
	input  logic [SLOT_W-1:0] pop_step,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status
);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
	localparam logic [SLOT_W:0] SLOTS_EXT = (SLOT_W + 1)'(TABLE_SLOTS);

	logic [ENTRY_W-1:0] mem [TABLE_SLOTS];

	back_state_t        state_q, state_nx;
	job_t               job_q;
	logic [SLOT_W-1:0]  pos_q, step_q, cnt_q, clr_q;
	logic [ENTRY_W-1:0] rdata_q;
	status_t            status_q, res_status;
	logic               out_valid_q;

	logic [ENTRY_W-1:0] entry;
	logic               hit, slot_empty, last_probe, stop, out_free, finish;
	logic               we;
	logic [SLOT_W-1:0]  waddr, pos_nx;
	logic [ENTRY_W-1:0] wdata;
	logic [SLOT_W:0]    pos_sum;

	assign entry = {job_q.len, job_q.syms};
	assign hit = (rdata_q == entry);
	assign slot_empty = (rdata_q[ENTRY_W-1 -: LEN_W] == '0);
	assign last_probe = (cnt_q == LAST_SLOT);
	assign stop = job_q.zero_len || hit || slot_empty || last_probe;
	assign out_free = !out_valid_q || out_ready;
	assign finish = (state_q == B_CHECK) && stop && out_free;

	assign pos_sum = {1'b0, pos_q} + {1'b0, step_q};
	assign pos_nx = (pos_sum >= SLOTS_EXT) ? SLOT_W'(pos_sum - SLOTS_EXT)
		: pos_sum[SLOT_W-1:0];

	always_comb begin
		priority if (job_q.zero_len) begin
			res_status = ST_ABSENT;
		end else if (hit) begin
			res_status = ST_PRESENT;
		end else if (slot_empty) begin
			res_status = ST_ABSENT;
		end else begin
			res_status = ST_FULL;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			B_CLEAR: begin
				if (clr_q == LAST_SLOT) begin
					state_nx = B_IDLE;
				end
			end
			B_IDLE: begin
				if (pop_valid) begin
					state_nx = B_READ;
				end
			end
			B_READ: state_nx = B_CHECK;
			B_CHECK: begin
				if (finish) begin
					state_nx = B_IDLE;
				end else if (!stop) begin
					state_nx = B_READ;
				end
			end
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		clearing = (state_q == B_CLEAR);
		pop_ready = (state_q == B_IDLE);
		we = clearing || (finish && !job_q.zero_len && !hit && slot_empty
			&& job_q.cmd == CMD_INSERT);
		waddr = clearing ? clr_q : pos_q;
		wdata = clearing ? '0 : entry;
		out_valid = out_valid_q;
		status = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (clearing) begin
				clr_q <= clr_q + SLOT_W'(1);
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			job_q <= pop_job;
			pos_q <= pop_pos;
			step_q <= pop_step;
			cnt_q <= '0;
		end else if (state_q == B_CHECK && !stop) begin
			pos_q <= pos_nx;
			cnt_q <= cnt_q + SLOT_W'(1);
		end
		if (finish) begin
			status_q <= res_status;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (state_q == B_READ) begin
			rdata_q <= mem[pos_q];
		end
	end

endmodule

FILE: hdl/double_hash_dictionary.sv
// Top level of the double-hash dictionary: front, queue and back wired together.
//
// The block keeps a set of nucleotide strings of up to MAX_LEN symbols in an
// open-addressed table of TABLE_SLOTS slots (a prime) and answers one insert or
// find per request with status absent (inserted for a non-empty insert),
// present or full. After reset the table is swept clean, one slot per clock,
// and in_ready stays low until the sweep is done. The front computes the key
// modulo N and modulo N-1 by Horner's rule, one symbol per clock. A two-entry
// queue hands the residues to the back, which owns the single-port table: it
// picks up a request in its idle state, and each probe is a read state
// followed by a check state. The sustained rate is the slower of the two
// ends; while the back probes, the front already hashes the next string. The
// result sits in an output register, and the back only stalls when that
// register is still full.
module double_hash_dictionary import dhd_pkg::*; #(
	parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
	parameter int MAX_LEN = DEF_MAX_LEN
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic [LEN_W-1:0] length,
	input  logic [SYM_W-1:0] symbols,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int Q_W = JOB_W + 2 * SLOT_W;

	logic              clearing;
	logic              push_valid, push_ready, pop_valid, pop_ready;
	job_t              push_job, pop_job;
	logic [SLOT_W-1:0] push_pos, push_step, pop_pos, pop_step;
	logic [Q_W-1:0]    push_data, pop_data;

	// The front only takes requests once the table sweep after reset is done.
	dhd_front #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.MAX_LEN(MAX_LEN),
		.SLOT_W(SLOT_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.enable(!clearing),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.length(length),
		.symbols(symbols),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job(push_job),
		.push_pos(push_pos),
		.push_step(push_step)
	);

	assign push_data = {push_job, push_pos, push_step};
	assign {pop_job, pop_pos, pop_step} = pop_data;

	// Requests leave the queue in arrival order, so results keep that order.
	dhd_queue #(
		.W(Q_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	dhd_back #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.SLOT_W(SLOT_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.clearing(clearing),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_job(pop_job),
		.pop_pos(pop_pos),
		.pop_step(pop_step),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status)
	);

`ifndef SYNTHESIS
	// The front must hold a pending transfer into the queue until it is taken.
	a_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> (push_valid && $stable(push_data)))
		else $error("front dropped or changed a pending queue transfer");

	// No result may appear while the table is still being swept.
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!out_valid && !pop_ready))
		else $error("back produced work during the table sweep");

	// Only the three defined status codes ever leave the block.
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_ABSENT || status == ST_PRESENT
			|| status == ST_FULL))
		else $error("undefined status code on the result");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the double-hash nucleotide dictionary.
module tb_top;
	import dhd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SLOTS = DEF_TABLE_SLOTS;
	localparam int MAX_LEN = DEF_MAX_LEN;
	localparam int KEY_RADIX = 5;
	localparam int RANDOM_ITEMS = 550;
	localparam int IDLE_PERCENT = 11;
	// The trailing wait covers the front and one light probe at the back,
	// with a wide margin.
	localparam int TAIL_CYCLES = 40;
	// The slowest correct run is dominated by the clearing sweep after reset
	// and by a few hundred requests, each costing the front its hashing and
	// the back a handful of probes at this light load, stretched by idling on
	// both sides. The limit below leaves ample room for all of it.
	localparam int CYCLE_LIMIT = 2_000_000;

	// A row of the directed part. Rows with a typed answer carry it in
	// want; the rest are answered by the predictor.
	typedef struct {
		cmd_t        op;
		logic [3:0]  len;
		logic [23:0] sym;
		logic        typed;
		status_t     want;
	} stim_row_t;

	localparam int NUM_DIRECTED = 23;

	stim_row_t directed_rows [NUM_DIRECTED] = '{
		// The table is empty right after reset.
		'{CMD_FIND,   4'd1,  24'h000000, 1'b1, ST_ABSENT},
		'{CMD_INSERT, 4'd1,  24'h000000, 1'b1, ST_ABSENT},
		'{CMD_FIND,   4'd1,  24'h000000, 1'b1, ST_PRESENT},
		'{CMD_INSERT, 4'd1,  24'h000000, 1'b1, ST_PRESENT},
		// Symbol bits above the length must be ignored.
		'{CMD_FIND,   4'd1,  24'hFFFFFC, 1'b1, ST_PRESENT},
		'{CMD_FIND,   4'd1,  24'h000003, 1'b1, ST_ABSENT},
		// The empty string answers absent and is never written.
		'{CMD_INSERT, 4'd0,  24'hFFFFFF, 1'b1, ST_ABSENT},
		'{CMD_FIND,   4'd0,  24'h000000, 1'b1, ST_ABSENT},
		'{CMD_INSERT, 4'd0,  24'h000000, 1'b1, ST_ABSENT},
		// Longest string of all T, then lengths above the maximum, which
		// saturate and so name the same string.
		'{CMD_INSERT, 4'd12, 24'hFFFFFF, 1'b0, ST_ABSENT},
		'{CMD_FIND,   4'd15, 24'hFFFFFF, 1'b1, ST_PRESENT},
		'{CMD_INSERT, 4'd13, 24'hFFFFFF, 1'b1, ST_PRESENT},
		'{CMD_FIND,   4'd12, 24'h000000, 1'b0, ST_ABSENT},
		'{CMD_INSERT, 4'd12, 24'h000000, 1'b0, ST_ABSENT},
		'{CMD_FIND,   4'd12, 24'h000000, 1'b1, ST_PRESENT},
		'{CMD_INSERT, 4'd14, 24'h555555, 1'b0, ST_ABSENT},
		'{CMD_FIND,   4'd12, 24'h555555, 1'b1, ST_PRESENT},
		'{CMD_INSERT, 4'd2,  24'h00000E, 1'b0, ST_ABSENT},
		'{CMD_FIND,   4'd2,  24'hABCDEE, 1'b1, ST_PRESENT},
		'{CMD_INSERT, 4'd6,  24'hAAAAAA, 1'b0, ST_ABSENT},
		'{CMD_FIND,   4'd6,  24'h000AAA, 1'b1, ST_PRESENT},
		// A trailing A makes a different string of one more symbol.
		'{CMD_FIND,   4'd7,  24'h000AAA, 1'b0, ST_ABSENT},
		'{CMD_INSERT, 4'd3,  24'h00001B, 1'b0, ST_ABSENT}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [3:0]  length;
	logic [23:0] symbols;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;

	// Shadow copy of the slot store and the answers still owed by the block.
	logic [27:0] slot_image [TABLE_SLOTS];
	status_t     status_due [$];
	// Strings that were sent for insertion, kept raw as {length, symbols}.
	logic [27:0] known_words [$];

	int          mismatches;
	int          cycles;
	// While set, neither side idles.
	logic        steady;

	double_hash_dictionary #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.MAX_LEN(MAX_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.length(length),
		.symbols(symbols),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Global watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// Looks a string up in the shadow table exactly as the block should:
	// saturate the length, mask the unused symbols, form the base-5 key,
	// then walk the double-hash probe sequence. An insert claims the first
	// empty slot it meets.
	function automatic status_t dict_lookup(input cmd_t op, input logic [3:0] len_in,
			input logic [23:0] sym_in);
		int unsigned       n_sym;
		logic [23:0]       kept;
		logic [27:0]       word;
		longint unsigned   key;
		longint unsigned   weight;
		longint unsigned   pos;
		longint unsigned   stride;
		n_sym = (len_in > MAX_LEN) ? MAX_LEN : len_in;
		if (n_sym == 0)
			return ST_ABSENT;
		kept = '0;
		key = 0;
		weight = 1;
		for (int i = 0; i < n_sym; i++) begin
			kept[2*i +: 2] = sym_in[2*i +: 2];
			key += weight * (longint'(sym_in[2*i +: 2]) + 1);
			weight *= KEY_RADIX;
		end
		word = {4'(n_sym), kept};
		pos = key % TABLE_SLOTS;
		stride = 1 + key % (TABLE_SLOTS - 1);
		for (int p = 0; p < TABLE_SLOTS; p++) begin
			if (slot_image[pos] == word)
				return ST_PRESENT;
			if (slot_image[pos][27:24] == 4'd0) begin
				if (op == CMD_INSERT)
					slot_image[pos] = word;
				return ST_ABSENT;
			end
			pos = (pos + stride) % TABLE_SLOTS;
		end
		return ST_FULL;
	endfunction

	// Offers one request, idling at random beforehand, and records the answer
	// owed once the transfer has happened. Returns at the accepting edge.
	task automatic send_request(input cmd_t op, input logic [3:0] len, input logic [23:0] sym,
			input logic typed, input status_t want);
		status_t predicted;
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		length <= len;
		symbols <= sym;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = dict_lookup(op, len, sym);
		status_due.push_back(typed ? want : predicted);
	endtask

	// Holds the sender back until every owed answer has been returned.
	task automatic wait_all_answered;
		in_valid <= 1'b0;
		@(posedge clk);
		while (status_due.size() != 0)
			@(posedge clk);
	endtask

	// Lengths: mostly legal, sometimes empty, sometimes above the maximum.
	function automatic logic [3:0] pick_length;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 4)
			return 4'd0;
		if (r < 10)
			return 4'($urandom_range(15, 13));
		return 4'($urandom_range(MAX_LEN, 1));
	endfunction

	// Result side: every transfer out is checked against the oldest owed
	// answer; the ready line idles at random outside the steady window.
	always @(posedge clk) begin : result_check
		status_t want;
		if (arst_n && out_valid && out_ready) begin
			if (status_due.size() == 0) begin
				note_mismatch($sformatf("status %0d with no request outstanding", status));
			end else begin
				want = status_due.pop_front();
				if (status !== want)
					note_mismatch($sformatf("status %0d, expected %0d", status, want));
			end
		end
		out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
	end

	initial begin
		int unsigned r;
		int unsigned n_sym;
		int unsigned pick;
		logic [3:0]  len;
		logic [23:0] sym;
		logic [27:0] w;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_INSERT;
		length = '0;
		symbols = '0;
		out_ready = 1'b0;
		steady = 1'b0;
		mismatches = 0;
		cycles = 0;
		foreach (slot_image[i])
			slot_image[i] = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The block first sweeps its table, so the first
		// transfer waits on in_ready until the sweep is done.
		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].len, directed_rows[i].sym,
				directed_rows[i].typed, directed_rows[i].want);
		wait_all_answered();

		// Random part: mostly inserts of fresh strings and lookups of strings
		// already sent, the lookups with junk above the length, plus
		// repeated inserts, random lookups and odd lengths.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			steady = (k >= 250 && k < 350);
			r = $urandom_range(99);
			if (r < 40 || known_words.size() == 0) begin
				len = pick_length();
				sym = 24'($urandom());
				send_request(CMD_INSERT, len, sym, 1'b0, ST_ABSENT);
				if (len != 4'd0)
					known_words.push_back({len, sym});
			end else if (r < 80) begin
				pick = $urandom_range(known_words.size() - 1);
				w = known_words[pick];
				len = w[27:24];
				n_sym = (len > MAX_LEN) ? MAX_LEN : len;
				if (r < 70) begin
					sym = 24'($urandom());
					for (int i = 0; i < n_sym; i++)
						sym[2*i +: 2] = w[2*i +: 2];
					if (n_sym == MAX_LEN && $urandom_range(1) == 1)
						len = 4'($urandom_range(15, MAX_LEN));
					send_request(CMD_FIND, len, sym, 1'b0, ST_ABSENT);
				end else begin
					send_request(CMD_INSERT, len, w[23:0], 1'b0, ST_ABSENT);
				end
			end else if (r < 92) begin
				send_request(CMD_FIND, pick_length(), 24'($urandom()), 1'b0, ST_ABSENT);
			end else begin
				len = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15, 13));
				send_request(cmd_t'($urandom_range(1)), len, 24'($urandom()), 1'b0,
					ST_ABSENT);
			end
		end
		steady = 1'b0;

		wait_all_answered();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/dhd_pkg.sv
hdl/dhd_front.sv
hdl/dhd_queue.sv
hdl/dhd_back.sv
hdl/double_hash_dictionary.sv
bench/tb_top.sv
